[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define QMN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define QMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/qmn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_pkg
// shared types, constants and the reciprocal square root seed table
// ----------------------------------------------------------------------------
package qmn_pkg;

   localparam int CompWidth = 16;
   localparam int FifoDepth = 4;
   localparam int FifoAw    = 2;

   typedef logic signed [CompWidth-1:0] comp_type;

   // rounded product waiting for the back end
   typedef struct packed {
      logic [3:0][CompWidth-1:0] q;
      logic                      sat;
   } quat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // seed for 2^31/sqrt(m), m in [1,4), indexed by the top four bits of m
   function automatic logic [31:0] rsq_seed(input logic [3:0] idx);
      logic [31:0] v;
      unique case (idx)
         4'd0, 4'd1, 4'd2, 4'd3: v = 32'd2147483648;
         4'd4:  v = 32'd2024667000;
         4'd5:  v = 32'd1831380197;
         4'd6:  v = 32'd1684624762;
         4'd7:  v = 32'd1568300317;
         4'd8:  v = 32'd1473161628;
         4'd9:  v = 32'd1393471388;
         4'd10: v = 32'd1325455684;
         4'd11: v = 32'd1266516749;
         4'd12: v = 32'd1214800189;
         4'd13: v = 32'd1168942051;
         4'd14: v = 32'd1127913688;
         4'd15: v = 32'd1090922767;
         default: v = 32'd2147483648;
      endcase
      return v;
   endfunction

endpackage

[rtl/qmn_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_front
// accepts operand pairs, forms the hamilton product and rounds it to 16 bits
// ----------------------------------------------------------------------------
module qmn_front #(
   parameter int FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [127:0]            in_data,
   output logic                    push,
   output qmn_pkg::quat_type       push_data,
   input  qmn_pkg::fifo_status_type fifo_status
);

   localparam logic signed [34:0] Half = 35'sd1 <<< (FRAC_BITS - 1);

   qmn_pkg::comp_type   a [4];
   qmn_pkg::comp_type   b [4];
   logic signed [31:0]  pr_ff [4][4];
   logic                v1_ff;
   logic                v2_ff;
   qmn_pkg::quat_type   q_ff;
   qmn_pkg::quat_type   q_in;
   logic signed [34:0]  sm [4];
   logic                en;

   // round half up, shift down and clip
   function automatic logic [16:0] rnd(input logic signed [34:0] p);
      logic signed [34:0] r;
      logic [16:0]        o;
      r = (p + Half) >>> FRAC_BITS;
      if (r > 35'sd32767) begin
         o = {1'b1, 16'h7fff};
      end else if (r < -35'sd32768) begin
         o = {1'b1, 16'h8000};
      end else begin
         o = {1'b0, r[15:0]};
      end
      return o;
   endfunction

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a[i] = $signed(in_data[16*i +: 16]);
         b[i] = $signed(in_data[64 + 16*i +: 16]);
      end
   end

   assign push     = v2_ff && !fifo_status.full;
   assign en       = !v2_ff || !fifo_status.full;
   assign in_ready = en;
   assign push_data = q_ff;

   // index order x, y, z, w
   always_comb begin
      logic [16:0] t;
      sm[0] = 35'(pr_ff[3][0]) + 35'(pr_ff[0][3]) + 35'(pr_ff[1][2]) - 35'(pr_ff[2][1]);
      sm[1] = 35'(pr_ff[3][1]) + 35'(pr_ff[1][3]) + 35'(pr_ff[2][0]) - 35'(pr_ff[0][2]);
      sm[2] = 35'(pr_ff[3][2]) + 35'(pr_ff[2][3]) + 35'(pr_ff[0][1]) - 35'(pr_ff[1][0]);
      sm[3] = 35'(pr_ff[3][3]) - 35'(pr_ff[0][0]) - 35'(pr_ff[1][1]) - 35'(pr_ff[2][2]);
      q_in = '0;
      for (int k = 0; k < 4; k++) begin
         t = rnd(sm[k]);
         q_in.q[k] = t[15:0];
         q_in.sat  = q_in.sat | t[16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               pr_ff[i][j] <= 32'(a[i] * b[j]);
            end
         end
         q_ff <= q_in;
      end
   end

endmodule

[rtl/qmn_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_fifo
// short queue between the front and back ends
// ----------------------------------------------------------------------------
module qmn_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  qmn_pkg::quat_type        push_data,
   input  logic                     pop,
   output qmn_pkg::quat_type        pop_data,
   output qmn_pkg::fifo_status_type status
);

   qmn_pkg::quat_type              mem_ff [qmn_pkg::FifoDepth];
   logic [qmn_pkg::FifoAw-1:0]     wr_ff;
   logic [qmn_pkg::FifoAw-1:0]     rd_ff;
   logic [qmn_pkg::FifoAw:0]       cnt_ff;

   assign status.full  = cnt_ff == (qmn_pkg::FifoAw + 1)'(qmn_pkg::FifoDepth);
   assign status.empty = cnt_ff == '0;
   assign pop_data     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/qmn_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_back
// length, reciprocal square root by newton steps, scaling and output register
// ----------------------------------------------------------------------------
module qmn_back #(
   parameter int FRAC_BITS    = 14,
   parameter int NEWTON_STEPS = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qmn_pkg::quat_type        pop_data,
   input  qmn_pkg::fifo_status_type fifo_status,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [63:0]              out_data,
   output logic [1:0]               out_user
);

   localparam int NS = 7 + 3*NEWTON_STEPS;
   localparam int PS = 5 + 3*NEWTON_STEPS;
   localparam logic [33:0] Three = 34'd3 << 31;
   localparam logic [31:0] YCap  = 32'd1 << 31;

   typedef struct packed {
      logic [3:0][15:0] q;
      logic             sat;
      logic             zl;
      logic [4:0]       t;
      logic [32:0]      s;
      logic [3:0][31:0] sq;
      logic [31:0]      m32;
      logic [31:0]      y;
      logic [31:0]      y2;
      logic [33:0]      e;
      logic [5:0]       sh;
      logic [3:0][47:0] prod;
      logic [3:0][16:0] r;
   } bk_type;

   bk_type       st_ff [NS];
   bk_type       st_in [NS];
   logic [NS-1:0] v_ff;
   logic         en;
   logic [63:0]  dat_ff;
   logic [63:0]  dat_in;
   logic [1:0]   usr_ff;
   logic [1:0]   usr_in;
   logic         ov_ff;

   assign en        = !ov_ff || out_ready;
   assign pop       = en && !fifo_status.empty;
   assign out_valid = ov_ff;
   assign out_data  = dat_ff;
   assign out_user  = usr_ff;

   always_comb begin
      logic [5:0]   b;
      logic [63:0]  sl;
      logic [63:0]  y2w;
      logic [63:0]  ew;
      logic [33:0]  d;
      logic [65:0]  yd;
      logic [33:0]  yn;
      logic [15:0]  mag;
      logic [63:0]  rr;
      int           ix;
      // stage 0: fifo head
      st_in[0]     = '0;
      st_in[0].q   = pop_data.q;
      st_in[0].sat = pop_data.sat;
      // stage 1: squares
      st_in[1] = st_ff[0];
      for (int k = 0; k < 4; k++) begin
         st_in[1].sq[k] = 32'($signed(st_ff[0].q[k]) * $signed(st_ff[0].q[k]));
      end
      // stage 2: sum of squares
      st_in[2]   = st_ff[1];
      st_in[2].s = 33'(st_ff[1].sq[0]) + 33'(st_ff[1].sq[1])
                 + 33'(st_ff[1].sq[2]) + 33'(st_ff[1].sq[3]);
      // stage 3: leading one, even shift count
      b = '0;
      for (int i = 0; i < 33; i++) begin
         if (st_ff[2].s[i]) begin
            b = 6'(i);
         end
      end
      st_in[3]    = st_ff[2];
      st_in[3].zl = st_ff[2].s == '0;
      st_in[3].t  = 5'((6'd63 - b) >> 1);
      // stage 4: normalized sum of squares and seed
      sl = 64'(st_ff[3].s) << {st_ff[3].t, 1'b0};
      st_in[4]     = st_ff[3];
      st_in[4].m32 = sl[63:32];
      st_in[4].y   = qmn_pkg::rsq_seed(sl[63:60]);
      // newton steps, three stages each
      for (int n = 0; n < NEWTON_STEPS; n++) begin
         ix = 5 + 3*n;
         y2w = 64'(st_ff[ix-1].y) * 64'(st_ff[ix-1].y);
         st_in[ix]    = st_ff[ix-1];
         st_in[ix].y2 = y2w[62:31];
         ew = 64'(st_ff[ix].m32) * 64'(st_ff[ix].y2);
         st_in[ix+1]   = st_ff[ix];
         st_in[ix+1].e = 34'(ew >> 30);
         d  = (st_ff[ix+1].e >= Three) ? 34'd0 : Three - st_ff[ix+1].e;
         yd = 66'(st_ff[ix+1].y) * 66'(d);
         yn = yd[65:32];
         st_in[ix+2]   = st_ff[ix+1];
         st_in[ix+2].y = (yn > 34'(YCap)) ? YCap : yn[31:0];
      end
      // magnitude times reciprocal length
      st_in[PS]    = st_ff[PS-1];
      st_in[PS].sh = 6'(62 - FRAC_BITS) - 6'(st_ff[PS-1].t);
      for (int k = 0; k < 4; k++) begin
         mag = st_ff[PS-1].q[k][15] ? 16'(-st_ff[PS-1].q[k]) : st_ff[PS-1].q[k];
         st_in[PS].prod[k] = 48'(mag) * 48'(st_ff[PS-1].y);
      end
      // round and shift down, clamp magnitude
      st_in[PS+1] = st_ff[PS];
      for (int k = 0; k < 4; k++) begin
         rr = (64'(st_ff[PS].prod[k]) + (64'd1 << (st_ff[PS].sh - 6'd1))) >> st_ff[PS].sh;
         st_in[PS+1].r[k] = (rr > 64'd65536) ? 17'd65536 : rr[16:0];
      end
      // sign restore, clip, zero case
      dat_in = '0;
      usr_in = '0;
      if (st_ff[NS-1].zl) begin
         usr_in[0] = 1'b1;
      end else begin
         usr_in[1] = st_ff[NS-1].sat;
         for (int k = 0; k < 4; k++) begin
            if (st_ff[NS-1].q[k][15]) begin
               if (st_ff[NS-1].r[k] > 17'd32768) begin
                  dat_in[16*k +: 16] = 16'h8000;
                  usr_in[1] = 1'b1;
               end else begin
                  dat_in[16*k +: 16] = 16'(-st_ff[NS-1].r[k]);
               end
            end else begin
               if (st_ff[NS-1].r[k] > 17'd32767) begin
                  dat_in[16*k +: 16] = 16'h7fff;
                  usr_in[1] = 1'b1;
               end else begin
                  dat_in[16*k +: 16] = st_ff[NS-1].r[k][15:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[NS-2:0], pop};
         ov_ff <= v_ff[NS-1];
      end
      if (en) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
         dat_ff <= dat_in;
         usr_ff <= usr_in;
      end
   end

endmodule

[rtl/quaternion_multiply_normalize_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_top
// normalized hamilton product of two q2.14 quaternions
// ----------------------------------------------------------------------------
// takes one operand pair per cycle while the queue has room and returns one
// unit quaternion per pair, in order. the front end registers products and
// the rounded product; the back end registers the fifo head, squares, sum,
// leading-one search, seed lookup, three registered multiplies per newton
// step, scaling multiply, rounding shift and the output register. sustained
// rate is one item per cycle; a stalled result holds the back end while the
// 4-entry queue lets the front end keep taking items.
// a zero-length product returns zeros with zero_length set; saturated is set
// when a rounded product or a result component was clipped.
module quaternion_multiply_normalize_top #(
   parameter int FRAC_BITS    = 14,
   parameter int NEWTON_STEPS = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 bits each)
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r_x, r_y, r_z, r_w (16 bits each)
   output logic [63:0]  rsp_tdata,
   // zero_length, saturated
   output logic [1:0]   rsp_tuser
);

`include "assert_macros.svh"

   logic                     fifo_push;
   logic                     fifo_pop;
   qmn_pkg::quat_type        push_data;
   qmn_pkg::quat_type        pop_data;
   qmn_pkg::fifo_status_type fifo_status;

   // front end: products and rounding
   qmn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_data     (req_tdata),
      .push        (fifo_push),
      .push_data   (push_data),
      .fifo_status (fifo_status)
   );

   // decoupling queue
   qmn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   // back end: normalization and output register
   qmn_back #(.FRAC_BITS(FRAC_BITS), .NEWTON_STEPS(NEWTON_STEPS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .fifo_status (fifo_status),
      .pop         (fifo_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_user    (rsp_tuser)
   );

   // zero-length results carry zero components
   `QMN_ASSERT_NOW(a_zero_data, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "zero length with nonzero data")
   // zero length never comes with clipping
   `QMN_ASSERT_NOW(a_zero_sat, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "zero length and saturated together")
   // queue is never written when full or read when empty
   `QMN_ASSERT_NOW(a_fifo_ovf, clock, reset, fifo_push, !fifo_status.full || fifo_pop, "queue overflow")
   `QMN_ASSERT_NOW(a_fifo_udf, clock, reset, fifo_pop, !fifo_status.empty, "queue underflow")

endmodule

[tb/quaternion_multiply_normalize_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_top_tb
// randomized self-checking bench for the normalized quaternion product
// ----------------------------------------------------------------------------
// operand pairs go in on the req stream; a scoreboard computes the expected
// unit quaternion and flags of each accepted pair and compares every rsp
// transfer in order. directed corners come first, then random pairs with
// random gaps on both sides and one long receiver hold-off.
module quaternion_multiply_normalize_top_tb;

   localparam int FracBits    = 14;
   localparam int NewtonSteps = 2;
   localparam int NumRandom   = 1250;
   localparam int CycleLimit  = 200000;
   localparam int Drain       = 40;

   // expected result of one pair
   typedef struct {
      logic [15:0] r [4];
      logic        zero_len;
      logic        sat;
   } unit_quat_type;

   // normalized product predictor and queue of pending results
   class unit_quat_scoreboard;
      unit_quat_type pending [$];
      int            mismatches;

      function automatic longint clip16(longint v, ref bit sat);
         if (v > 32767) begin
            sat = 1;
            return 32767;
         end
         if (v < -32768) begin
            sat = 1;
            return -32768;
         end
         return v;
      endfunction

      function automatic longint round_prod(longint p, ref bit sat);
         longint r;
         r = (p + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
         return clip16(r, sat);
      endfunction

      function automatic logic [63:0] inv_sqrt(logic [63:0] m);
         logic [63:0] y, m32, y2, e, d;
         logic [63:0] three;
         three = 64'd3 << 31;
         y = 64'(qmn_pkg::rsq_seed(m[63:60]));
         m32 = m >> 32;
         for (int i = 0; i < NewtonSteps; i++) begin
            y2 = (y * y) >> 31;
            e = (m32 * y2) >> 30;
            d = (e >= three) ? 64'd0 : three - e;
            y = (y * d) >> 32;
            if (y > (64'd1 << 31))
               y = 64'd1 << 31;
         end
         return y;
      endfunction

      function void note_pair(logic [127:0] data);
         longint a [4], b [4], q [4];
         logic [63:0] s, m, y, mag, rr;
         int t, sh;
         bit sat, neg;
         longint v;
         unit_quat_type exp_r;
         for (int k = 0; k < 4; k++) begin
            a[k] = longint'($signed(data[16*k +: 16]));
            b[k] = longint'($signed(data[64 + 16*k +: 16]));
         end
         sat = 0;
         // index 0..3 = x, y, z, w
         q[0] = round_prod(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1], sat);
         q[1] = round_prod(a[3]*b[1] + a[1]*b[3] + a[2]*b[0] - a[0]*b[2], sat);
         q[2] = round_prod(a[3]*b[2] + a[2]*b[3] + a[0]*b[1] - a[1]*b[0], sat);
         q[3] = round_prod(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2], sat);
         s = 0;
         for (int k = 0; k < 4; k++)
            s += 64'(q[k] * q[k]);
         if (s == 0) begin
            for (int k = 0; k < 4; k++)
               exp_r.r[k] = '0;
            exp_r.zero_len = 1;
            exp_r.sat = 0;
         end else begin
            m = s;
            t = 0;
            while (m < (64'd1 << 62)) begin
               m = m << 2;
               t++;
            end
            y = inv_sqrt(m);
            sh = 62 - FracBits - t;
            for (int k = 0; k < 4; k++) begin
               neg = q[k] < 0;
               mag = 64'(neg ? -q[k] : q[k]);
               rr = (mag * y + (64'd1 << (sh - 1))) >> sh;
               if (rr > 64'd65536)
                  rr = 64'd65536;
               v = neg ? -longint'(rr) : longint'(rr);
               v = clip16(v, sat);
               exp_r.r[k] = v[15:0];
            end
            exp_r.zero_len = 0;
            exp_r.sat = sat;
         end
         pending.push_back(exp_r);
      endfunction

      function void check_result(logic [63:0] data, logic [1:0] user);
         unit_quat_type e;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h user %b", data, user);
            return;
         end
         e = pending.pop_front();
         bad = (user[0] !== e.zero_len) || (user[1] !== e.sat);
         for (int k = 0; k < 4; k++)
            if (data[16*k +: 16] !== e.r[k])
               bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h %h %h zl %b sat %b, got %h zl %b sat %b",
                  e.r[0], e.r[1], e.r[2], e.r[3], e.zero_len, e.sat,
                  data, user[0], user[1]);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   unit_quat_scoreboard board;
   logic [127:0] directed [$];
   bit           hold_off;
   bit           stim_done;
   int           cycles = 0;

   quaternion_multiply_normalize_top #(
      .FRAC_BITS   (FracBits),
      .NEWTON_STEPS(NewtonSteps)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // sample both streams at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_pair(req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // cycle watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("quaternion_multiply_normalize_top_tb: FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] rand_comp();
      int sel;
      sel = $urandom_range(0, 9);
      // mostly everyday magnitudes, sometimes extremes or tiny values
      case (sel)
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 4)) - 16'd2;
         3, 4: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [127:0] rand_pair();
      logic [127:0] d;
      int kind;
      kind = $urandom_range(0, 19);
      for (int k = 0; k < 8; k++)
         d[16*k +: 16] = rand_comp();
      // occasionally a zero operand or a full-range raw word
      if (kind == 0)
         d[63:0] = '0;
      else if (kind == 1)
         d[127:64] = '0;
      else if (kind == 2)
         d = {$urandom, $urandom, $urandom, $urandom};
      return d;
   endfunction

   // offer one pair after an idle gap and wait for its transfer;
   // valid stays high into the next call when that one has no gap
   task automatic send_pair(logic [127:0] d, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // receiver: random stalls per result, plus one long hold-off
   initial begin
      int wait_n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         wait_n = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0)
            wait_n = 0;
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      board = new();
      hold_off = 0;
      stim_done = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      // identity times identity, zero, extremes, sign corners
      directed.push_back({16'h4000, 48'h0, 16'h4000, 48'h0});
      directed.push_back('0);
      directed.push_back({64'h0, {4{16'h7fff}}});
      directed.push_back({128{1'b1}} ^ {128{1'b1}} | {8{16'h7fff}});
      directed.push_back({8{16'h8000}});
      directed.push_back({{4{16'h8000}}, {4{16'h7fff}}});
      directed.push_back({{4{16'h7fff}}, {4{16'h8000}}});
      directed.push_back({16'h0001, 48'h0, 16'h0001, 48'h0});
      directed.push_back({16'h0080, 48'h0, 16'h0080, 48'h0});
      directed.push_back({16'h0001, 48'h0, 16'h0000, 48'h1});
      directed.push_back({16'hffff, 48'h0, 16'hffff, 48'h0});
      directed.push_back({16'h4000, 48'h0, 16'h0, 16'h4000, 32'h0});
      directed.push_back({16'h4000, 48'h0, 32'h0, 16'h4000, 16'h0});
      directed.push_back({16'h4000, 48'h0, 48'h0, 16'h4000});
      directed.push_back({16'h2d41, 16'h2d41, 32'h0, 16'h2d41, 16'h0, 16'h2d41, 16'h0});
      directed.push_back({{4{16'h5555}}, {4{16'haaaa}}});
      directed.push_back({{4{16'haaaa}}, {4{16'h5555}}});
      directed.push_back({16'h7fff, 48'h0, 16'h7fff, 48'h0});
      directed.push_back({16'h0003, 48'h0, 16'h0000, 16'h0003, 32'h0});
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i])
         send_pair(directed[i], $urandom_range(0, 3));
      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom / 2)
            hold_off = 1;
         // back-to-back bursts fill the pipe
         if ($urandom_range(0, 4) == 0)
            send_pair(rand_pair(), 0);
         else
            send_pair(rand_pair(), $urandom_range(0, 3));
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("quaternion_multiply_normalize_top_tb: PASS");
      end else begin
         $display("quaternion_multiply_normalize_top_tb: FAIL");
      end
      $finish;
   end

endmodule

[quaternion_multiply_normalize_top.f]
+incdir+rtl
rtl/qmn_pkg.sv
rtl/qmn_front.sv
rtl/qmn_fifo.sv
rtl/qmn_back.sv
rtl/quaternion_multiply_normalize_top.sv
tb/quaternion_multiply_normalize_top_tb.sv
